### rtl/jkvt_pkg.sv
// Package for the JSON key/value tokenizer: result item types, event codes,
// parse phases, register indexes and character constants.
// No dependencies.
`timescale 1ns / 1ps

package jkvt_pkg;

	// Most result items one input byte can cause
	localparam int RES_MAX = 5;
	localparam int RES_IDX_W = $clog2(RES_MAX + 1);

	// Register limits and reset values
	localparam logic [6:0] KEY_SIZE_RST = 7'd20;
	localparam logic [7:0] VALUE_SIZE_RST = 8'd70;
	localparam logic [6:0] KEY_SIZE_MIN = 7'd1;
	localparam logic [6:0] KEY_SIZE_MAX = 7'd64;
	localparam logic [7:0] VALUE_SIZE_MIN = 8'd7;
	localparam logic [7:0] VALUE_SIZE_MAX = 8'd128;

	// Register indexes, decoded from the word address
	localparam logic REG_KEY_SIZE = 1'b0;
	localparam logic REG_VALUE_SIZE = 1'b1;

	// Characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef enum logic [2:0] {
		EV_KEY_WR = 3'd0,
		EV_VAL_WR = 3'd1,
		EV_PAIR = 3'd2,
		EV_KEY_OVF = 3'd3,
		EV_BAD_SEP = 3'd4,
		EV_NO_PAIR = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		PH_SEEK = 3'd0,
		PH_KEY = 3'd1,
		PH_SEP = 3'd2,
		PH_VALUE = 3'd3,
		PH_SKIP = 3'd4
	} phase_t;

	// Effective (saturated) buffer sizes
	typedef struct packed {
		logic [6:0] key_size;
		logic [7:0] value_size;
	} cfg_t;

	typedef struct packed {
		event_t ev;
		logic [6:0] idx;
		logic [7:0] data;
		logic [5:0] klen;
		logic [6:0] vlen;
	} res_t;

	// All results of one input byte
	typedef struct packed {
		logic [RES_IDX_W-1:0] cnt;
		res_t [RES_MAX-1:0] ent;
	} bundle_t;

	function automatic res_t make_res(input event_t ev, input logic [6:0] idx,
		input logic [7:0] data, input logic [5:0] klen, input logic [6:0] vlen);
		res_t r;
		r.ev = ev;
		r.idx = idx;
		r.data = data;
		r.klen = klen;
		r.vlen = vlen;
		return r;
	endfunction

endpackage

### rtl/json_key_value_tokenizer_unit.sv
// JSON key/value tokenizer, top level: configuration registers, parser and
// result sequencer. Depends on jkvt_pkg, jkvt_cfg_regs, jkvt_parser, jkvt_out_seq.
`timescale 1ns / 1ps

// Takes one text byte per cycle while in_ready is high and reports key/value
// buffer writes, pair completion with lengths, and errors. A byte is parsed in
// the cycle it is accepted and its results (zero to five items) land in the
// result register; they leave one item per cycle while out_ready is high, and
// the next byte is accepted in the same cycle as the last item of the previous
// one; with no output stall, bytes of at most one item run at one byte per
// cycle. A byte causing more items holds the input until its last is taken;
// the worst case is a value truncation at string end (five items). APB writes
// take effect on the next byte; key_size is at byte address 0, value_size at 4.
module json_key_value_tokenizer_unit import jkvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [6:0]  write_index,
	output logic [7:0]  write_byte,
	output logic [5:0]  key_length,
	output logic [6:0]  value_length,
	output logic        last_of_run
);

	cfg_t    cfg;
	bundle_t bundle;

	jkvt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jkvt_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.accept        (in_valid && in_ready),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.bundle        (bundle)
	);

	jkvt_out_seq u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.bundle       (bundle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.write_index  (write_index),
		.write_byte   (write_byte),
		.key_length   (key_length),
		.value_length (value_length),
		.last_of_run  (last_of_run)
	);

endmodule

### rtl/jkvt_cfg_regs.sv
// Configuration registers of the tokenizer behind an APB-style port.
// Depends on jkvt_pkg; outputs the saturated buffer sizes.
`timescale 1ns / 1ps

module jkvt_cfg_regs import jkvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [6:0] key_size_q;
	logic [7:0] value_size_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= KEY_SIZE_RST;
			value_size_q <= VALUE_SIZE_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_KEY_SIZE) begin
				key_size_q <= pwdata[6:0];
			end else begin
				value_size_q <= pwdata[7:0];
			end
		end
	end

	// Read back the raw register values
	always_comb begin
		if (paddr[2] == REG_KEY_SIZE) begin
			prdata = {25'd0, key_size_q};
		end else begin
			prdata = {24'd0, value_size_q};
		end
	end

	// Clamp sizes into their legal ranges
	always_comb begin
		priority if (key_size_q < KEY_SIZE_MIN) begin
			cfg.key_size = KEY_SIZE_MIN;
		end else if (key_size_q > KEY_SIZE_MAX) begin
			cfg.key_size = KEY_SIZE_MAX;
		end else begin
			cfg.key_size = key_size_q;
		end
		priority if (value_size_q < VALUE_SIZE_MIN) begin
			cfg.value_size = VALUE_SIZE_MIN;
		end else if (value_size_q > VALUE_SIZE_MAX) begin
			cfg.value_size = VALUE_SIZE_MAX;
		end else begin
			cfg.value_size = value_size_q;
		end
	end

endmodule

### rtl/jkvt_parser.sv
// Parse state of the tokenizer and the single-pass logic that turns one
// accepted byte into its bundle of result items. Depends on jkvt_pkg.
`timescale 1ns / 1ps

module jkvt_parser import jkvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	output bundle_t    bundle
);

	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic [5:0]  kc_q, kc_d;
	logic [6:0]  vc_q, vc_d;
	logic [39:0] rec_q, rec_d;
	logic        drain_q, drain_d;

	logic                 err, done;
	logic                 do_key, do_val, val_chk, do_pair, do_badsep;
	logic                 key_room, val_room;
	logic [7:0]           vs_m2, vs_m3, vs_m4, vs_m5;
	logic [RES_IDX_W-1:0] n;
	res_t [RES_MAX-1:0]   ent;

	assign key_room = {1'b0, kc_q} < (cfg.key_size - 7'd1);
	assign val_room = {1'b0, vc_q} < (cfg.value_size - 8'd1);
	assign vs_m2 = cfg.value_size - 8'd2;
	assign vs_m3 = cfg.value_size - 8'd3;
	assign vs_m4 = cfg.value_size - 8'd4;
	assign vs_m5 = cfg.value_size - 8'd5;

	// Next state and result items for the byte at the input
	always_comb begin
		phase_d = phase_q;
		esc_d = esc_q;
		kc_d = kc_q;
		vc_d = vc_q;
		rec_d = rec_q;
		drain_d = drain_q;
		err = 1'b0;
		done = 1'b0;
		do_key = 1'b0;
		do_val = 1'b0;
		val_chk = 1'b0;
		do_pair = 1'b0;
		do_badsep = 1'b0;
		n = '0;
		ent = '0;

		if (!drain_q) begin
			// Classify the byte by phase
			unique case (phase_q)
				PH_KEY: begin
					if (esc_q) begin
						do_key = 1'b1;
						esc_d = 1'b0;
					end else if (data_byte == CH_QUOTE) begin
						phase_d = PH_SEP;
					end else if (data_byte == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						do_key = 1'b1;
					end
				end
				PH_SEP: begin
					if (data_byte == CH_QUOTE) begin
						phase_d = PH_VALUE;
						esc_d = 1'b0;
						vc_d = '0;
						rec_d = '0;
					end else if (data_byte != CH_COLON && data_byte != CH_SPACE) begin
						do_badsep = 1'b1;
					end
				end
				PH_VALUE: begin
					if (esc_q) begin
						do_val = 1'b1;
						esc_d = 1'b0;
					end else if (data_byte == CH_QUOTE) begin
						do_pair = 1'b1;
					end else begin
						if (data_byte == CH_BSLASH) begin
							esc_d = 1'b1;
						end
						do_val = 1'b1;
						val_chk = 1'b1;
					end
				end
				PH_SKIP: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (data_byte == CH_QUOTE) begin
						do_pair = 1'b1;
					end else if (data_byte == CH_BSLASH) begin
						esc_d = 1'b1;
					end
				end
				default: begin
					if (data_byte == CH_QUOTE) begin
						phase_d = PH_KEY;
						esc_d = 1'b0;
						kc_d = '0;
						vc_d = '0;
						rec_d = '0;
					end else begin
						phase_d = PH_SEEK;
					end
				end
			endcase

			// Store a key byte or flag key overflow
			if (do_key) begin
				if (key_room) begin
					ent[n] = make_res(EV_KEY_WR, {1'b0, kc_q}, data_byte, 6'd0, 7'd0);
					n = n + 1'b1;
					kc_d = kc_q + 6'd1;
				end else begin
					ent[n] = make_res(EV_KEY_OVF, 7'd0, 8'd0, 6'd0, 7'd0);
					n = n + 1'b1;
					err = 1'b1;
				end
			end

			// Store a value byte, or write the truncation dots and skip the rest
			if (do_val) begin
				if (val_room) begin
					ent[n] = make_res(EV_VAL_WR, vc_q, data_byte, 6'd0, 7'd0);
					n = n + 1'b1;
					rec_d = {rec_q[31:0], data_byte};
					vc_d = vc_q + 7'd1;
				end else begin
					ent[n] = make_res(EV_VAL_WR, vs_m2[6:0], CH_DOT, 6'd0, 7'd0);
					n = n + 1'b1;
					ent[n] = make_res(EV_VAL_WR, vs_m3[6:0], CH_DOT, 6'd0, 7'd0);
					n = n + 1'b1;
					ent[n] = make_res(EV_VAL_WR, vs_m4[6:0], CH_DOT, 6'd0, 7'd0);
					n = n + 1'b1;
					// Do not leave a dangling backslash before the dots
					if (val_chk && rec_q[31:24] == CH_BSLASH && rec_q[39:32] != CH_BSLASH) begin
						ent[n] = make_res(EV_VAL_WR, vs_m5[6:0], CH_DOT, 6'd0, 7'd0);
						n = n + 1'b1;
					end
					phase_d = PH_SKIP;
				end
			end

			if (do_pair) begin
				ent[n] = make_res(EV_PAIR, 7'd0, 8'd0, kc_q, vc_q);
				n = n + 1'b1;
				done = 1'b1;
				phase_d = PH_SEEK;
			end

			if (do_badsep) begin
				ent[n] = make_res(EV_BAD_SEP, 7'd0, 8'd0, 6'd0, 7'd0);
				n = n + 1'b1;
				err = 1'b1;
			end

			// Drain the rest of the string after an error
			if (err) begin
				drain_d = 1'b1;
				phase_d = PH_SEEK;
				esc_d = 1'b0;
			end
		end

		// Close the string: report an open value or the missing pair, then clear
		if (end_of_string) begin
			if (!drain_q && !err) begin
				if (phase_d == PH_VALUE || phase_d == PH_SKIP) begin
					ent[n] = make_res(EV_PAIR, 7'd0, 8'd0, kc_d, vc_d);
					n = n + 1'b1;
					done = 1'b1;
				end
				if (!done) begin
					ent[n] = make_res(EV_NO_PAIR, 7'd0, 8'd0, 6'd0, 7'd0);
					n = n + 1'b1;
				end
			end
			phase_d = PH_SEEK;
			esc_d = 1'b0;
			kc_d = '0;
			vc_d = '0;
			rec_d = '0;
			drain_d = 1'b0;
		end
	end

	assign bundle.cnt = n;
	assign bundle.ent = ent;

	// Advance the parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			esc_q <= 1'b0;
			kc_q <= '0;
			vc_q <= '0;
			rec_q <= '0;
			drain_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			esc_q <= esc_d;
			kc_q <= kc_d;
			vc_q <= vc_d;
			rec_q <= rec_d;
			drain_q <= drain_d;
		end
	end

endmodule

### rtl/jkvt_out_seq.sv
// Result register of the tokenizer: holds the bundle of one byte and hands
// its items out one per cycle while out_ready is high. Depends on jkvt_pkg.
`timescale 1ns / 1ps

module jkvt_out_seq import jkvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bundle_t    bundle,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [6:0] write_index,
	output logic [7:0] write_byte,
	output logic [5:0] key_length,
	output logic [6:0] value_length,
	output logic       last_of_run
);

	bundle_t              bundle_q;
	logic [RES_IDX_W-1:0] pos_q;
	logic                 valid_q;
	logic                 out_fire, in_fire, load, is_last;
	res_t                 cur;

	assign cur = bundle_q.ent[pos_q];
	assign is_last = (pos_q == bundle_q.cnt - 1'b1);
	assign out_fire = valid_q && out_ready;
	assign in_ready = !valid_q || (out_ready && is_last);
	assign in_fire = in_valid && in_ready;
	assign load = in_fire && (bundle.cnt != '0);

	// Load a new bundle or step through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q <= '0;
		end else if (out_fire) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	assign out_valid = valid_q;
	assign event_res = cur.ev;
	assign write_index = cur.idx;
	assign write_byte = cur.data;
	assign key_length = cur.klen;
	assign value_length = cur.vlen;
	assign last_of_run = is_last;

	a_pos_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (pos_q < bundle_q.cnt))
		else $error("result position past end of bundle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	a_drop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && is_last && !load) |=> !valid_q)
		else $error("result register still valid after last item taken");

	a_step_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !is_last) |=> (pos_q == $past(pos_q) + 1'b1))
		else $error("result position did not advance");

endmodule

### dv/testbench.sv
// Self-checking testbench for json_key_value_tokenizer_unit: byte driver, result
// monitor and a byte-level tokenizer predictor. Depends on jkvt_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;
	import jkvt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [7:0] b;
		logic eos;
	} text_item_t;

	typedef struct packed {
		event_t ev;
		logic [6:0] idx;
		logic [7:0] data;
		logic [5:0] klen;
		logic [6:0] vlen;
		logic last;
	} tok_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic end_of_string = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] event_res;
	logic [6:0] write_index;
	logic [7:0] write_byte;
	logic [5:0] key_length;
	logic [6:0] value_length;
	logic last_of_run;

	json_key_value_tokenizer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_string(end_of_string),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_res(event_res), .write_index(write_index), .write_byte(write_byte),
		.key_length(key_length), .value_length(value_length), .last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	// Pending text bytes, expected result items and bookkeeping
	text_item_t byte_feed[$];
	tok_res_t tok_expected[$];
	tok_res_t byte_results[$];
	int feed_queued = 0;
	int feed_sent = 0;
	int feed_taken = 0;
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Predictor copy of the registers and the parse state
	logic [6:0] cfg_key_size = KEY_SIZE_RST;
	logic [7:0] cfg_value_size = VALUE_SIZE_RST;
	phase_t tk_phase = PH_SEEK;
	logic tk_esc = 1'b0;
	logic [5:0] tk_keys = '0;
	logic [6:0] tk_vals = '0;
	logic [39:0] tk_recent = '0;
	logic tk_drain = 1'b0;

	function automatic void note_res(event_t ev, int idx, logic [7:0] data, int kl, int vl);
		tok_res_t r;
		r.ev = ev;
		r.idx = idx[6:0];
		r.data = data;
		r.klen = kl[5:0];
		r.vlen = vl[6:0];
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	// Advance the predicted parse state by one text byte and queue its results
	function automatic void tokenize_byte(logic [7:0] b, logic eos);
		logic err, done, was_drain, check;
		int ks, vs;
		logic [7:0] at5, at6;
		byte_results.delete();
		err = 1'b0;
		done = 1'b0;
		was_drain = tk_drain;
		ks = cfg_key_size;
		if (ks < 1) ks = 1;
		if (ks > 64) ks = 64;
		vs = cfg_value_size;
		if (vs < 7) vs = 7;
		if (vs > 128) vs = 128;

		if (!was_drain) begin
			case (tk_phase)
				PH_KEY: begin
					if (tk_esc || (b != CH_QUOTE && b != CH_BSLASH)) begin
						tk_esc = 1'b0;
						if (int'(tk_keys) < ks - 1) begin
							note_res(EV_KEY_WR, tk_keys, b, 0, 0);
							tk_keys++;
						end else begin
							note_res(EV_KEY_OVF, 0, 8'h00, 0, 0);
							err = 1'b1;
						end
					end else if (b == CH_QUOTE) begin
						tk_phase = PH_SEP;
					end else begin
						tk_esc = 1'b1;
					end
				end
				PH_SEP: begin
					if (b == CH_QUOTE) begin
						tk_phase = PH_VALUE;
						tk_esc = 1'b0;
						tk_vals = '0;
						tk_recent = '0;
					end else if (b != CH_COLON && b != CH_SPACE) begin
						note_res(EV_BAD_SEP, 0, 8'h00, 0, 0);
						err = 1'b1;
					end
				end
				PH_VALUE: begin
					if (!tk_esc && b == CH_QUOTE) begin
						note_res(EV_PAIR, 0, 8'h00, tk_keys, tk_vals);
						done = 1'b1;
						tk_phase = PH_SEEK;
					end else begin
						// an escaped byte never arms the backslash dot rule
						check = !tk_esc;
						if (tk_esc) tk_esc = 1'b0;
						else if (b == CH_BSLASH) tk_esc = 1'b1;
						if (int'(tk_vals) < vs - 1) begin
							note_res(EV_VAL_WR, tk_vals, b, 0, 0);
							tk_recent = {tk_recent[31:0], b};
							tk_vals++;
						end else begin
							at5 = tk_recent[31:24];
							at6 = tk_recent[39:32];
							note_res(EV_VAL_WR, vs - 2, CH_DOT, 0, 0);
							note_res(EV_VAL_WR, vs - 3, CH_DOT, 0, 0);
							note_res(EV_VAL_WR, vs - 4, CH_DOT, 0, 0);
							if (check && at5 == CH_BSLASH && at6 != CH_BSLASH)
								note_res(EV_VAL_WR, vs - 5, CH_DOT, 0, 0);
							tk_phase = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (tk_esc) begin
						tk_esc = 1'b0;
					end else if (b == CH_QUOTE) begin
						note_res(EV_PAIR, 0, 8'h00, tk_keys, tk_vals);
						done = 1'b1;
						tk_phase = PH_SEEK;
					end else if (b == CH_BSLASH) begin
						tk_esc = 1'b1;
					end
				end
				default: begin
					if (b == CH_QUOTE) begin
						tk_phase = PH_KEY;
						tk_esc = 1'b0;
						tk_keys = '0;
						tk_vals = '0;
						tk_recent = '0;
					end else begin
						tk_phase = PH_SEEK;
					end
				end
			endcase
			if (err) begin
				tk_drain = 1'b1;
				tk_phase = PH_SEEK;
				tk_esc = 1'b0;
			end
		end

		// Close out the string on its final byte
		if (eos) begin
			if (!was_drain && !err) begin
				if (tk_phase == PH_VALUE || tk_phase == PH_SKIP) begin
					note_res(EV_PAIR, 0, 8'h00, tk_keys, tk_vals);
					done = 1'b1;
				end
				if (!done) note_res(EV_NO_PAIR, 0, 8'h00, 0, 0);
			end
			tk_phase = PH_SEEK;
			tk_esc = 1'b0;
			tk_keys = '0;
			tk_vals = '0;
			tk_recent = '0;
			tk_drain = 1'b0;
		end

		if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i]) tok_expected.push_back(byte_results[i]);
	endfunction

	// Driver: present the next pending byte, predict each accepted one
	always @(posedge clk or negedge arst_n) begin : byte_driver
		text_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			end_of_string <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				tokenize_byte(data_byte, end_of_string);
				feed_taken++;
			end
			if (!in_valid || in_ready) begin
				if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = byte_feed.pop_front();
					data_byte <= nxt.b;
					end_of_string <= nxt.eos;
					in_valid <= 1'b1;
					feed_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		tok_res_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got.ev = event_t'(event_res);
				got.idx = write_index;
				got.data = write_byte;
				got.klen = key_length;
				got.vlen = value_length;
				got.last = last_of_run;
				if (tok_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: ev=%0d idx=%0d byte=%02h %s",
							got.ev, got.idx, got.data,
							$sformatf("klen=%0d vlen=%0d last=%0b",
								got.klen, got.vlen, got.last));
				end else begin
					want = tok_expected.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp ev=%0d idx=%0d byte=%02h %s",
								want.ev, want.idx, want.data,
								$sformatf("klen=%0d vlen=%0d last=%0b",
									want.klen, want.vlen, want.last));
							$display("          got ev=%0d idx=%0d byte=%02h %s",
								got.ev, got.idx, got.data,
								$sformatf("klen=%0d vlen=%0d last=%0b",
									got.klen, got.vlen, got.last));
						end
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic put(input logic [7:0] b, input bit eos);
		text_item_t it;
		it.b = b;
		it.eos = eos;
		byte_feed.push_back(it);
		feed_queued++;
	endtask

	task automatic put_str(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++) put(s[i], eos_last && i == s.len() - 1);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	// Queue one quoted pair with random content; flawed ones carry noise,
	// a bad separator, a missing close or an early end of string
	task automatic gen_pair(input int klen, input int vlen, input bit clean);
		logic [7:0] txt[$];
		logic [7:0] bad;
		int flaw, cut;
		flaw = clean ? 0 : $urandom_range(1, 5);
		if (flaw == 1) begin
			repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(0, 2)) txt.push_back(plain_byte());
			txt.push_back(CH_QUOTE);
			for (int i = 0; i < klen; i++) begin
				if ($urandom_range(5) == 0) begin
					txt.push_back(CH_BSLASH);
					txt.push_back(8'($urandom_range(255)));
				end else begin
					txt.push_back(plain_byte());
				end
			end
			txt.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(1) ? CH_COLON : CH_SPACE);
			if (flaw == 2) begin
				do bad = 8'($urandom_range(255));
				while (bad == CH_QUOTE || bad == CH_COLON || bad == CH_SPACE);
				txt.push_back(bad);
			end
			txt.push_back(CH_QUOTE);
			for (int i = 0; i < vlen; i++) begin
				if ($urandom_range(5) == 0) begin
					txt.push_back(CH_BSLASH);
					txt.push_back(8'($urandom_range(255)));
				end else begin
					txt.push_back(plain_byte());
				end
			end
			if (flaw != 3) txt.push_back(CH_QUOTE);
			if (flaw == 5) repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(255)));
		end
		cut = (flaw == 4) ? $urandom_range(0, txt.size() - 1) : txt.size() - 1;
		foreach (txt[i]) put(txt[i], i == cut || i == txt.size() - 1);
	endtask

	task automatic run_random(input int target, input int kmax, input int vmax);
		int start;
		start = feed_queued;
		while (feed_queued - start < target)
			gen_pair($urandom_range(0, kmax), $urandom_range(0, vmax), $urandom_range(99) >= 25);
	endtask

	// Hold until every byte is taken and every predicted item has arrived
	task automatic wait_idle();
		while (byte_feed.size() != 0 || feed_sent != feed_taken || tok_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_KEY_SIZE) cfg_key_size = val[6:0];
		else cfg_value_size = val[7:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset sizes, no idling: escapes in key and value, open value at end,
		// end without pair, bad separator, end inside a key
		send_idle_pct = 0;
		recv_stall_pct = 0;
		put_str("\"\\\"\" \"\\\"", 1);
		put(8'hFF, 1);
		put_str("\"k\"x", 1);
		put(8'h00, 0);
		put(CH_QUOTE, 1);
		wait_idle();

		// Smallest value buffer: truncation with the backslash dot, ended while skipping
		write_reg(REG_KEY_SIZE, 32'd2);
		write_reg(REG_VALUE_SIZE, 32'd7);
		send_idle_pct = 49;
		put_str("\"k\"\"ab\\xdef", 1);
		run_random(12, 3, 9);
		wait_idle();

		// Out-of-range low sizes saturate to the minimum
		write_reg(REG_KEY_SIZE, 32'd0);
		write_reg(REG_VALUE_SIZE, 32'd0);
		send_idle_pct = 0;
		recv_stall_pct = 49;
		run_random(12, 2, 9);
		wait_idle();

		// Out-of-range high sizes saturate to the maximum: full key
		write_reg(REG_KEY_SIZE, 32'h7F);
		write_reg(REG_VALUE_SIZE, 32'hFF);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		gen_pair(63, 2, 1'b1);
		run_random(8, 5, 8);
		wait_idle();

		// Single-slot key buffer: any non-empty key overflows on its first byte
		write_reg(REG_KEY_SIZE, 32'd1);
		write_reg(REG_VALUE_SIZE, 32'd8);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		run_random(12, 2, 10);
		wait_idle();

		// Random small sizes
		write_reg(REG_KEY_SIZE, 32'($urandom_range(1, 12)));
		write_reg(REG_VALUE_SIZE, 32'($urandom_range(7, 20)));
		send_idle_pct = 49;
		recv_stall_pct = 0;
		run_random(10, 12, 22);
		wait_idle();

		if (mismatches == 0 && tok_expected.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
